// ===== src/bdms_pkg.sv =====
package bdms_pkg;

  localparam int MaxSide    = 256;
  localparam int TexelW     = 16;
  localparam int AddrW      = 16;
  localparam int BankAw     = AddrW - 1;
  localparam int SideW      = 9;
  localparam int ScaleW     = 24;
  localparam int WorldW     = 24;
  localparam int ScaleFracW = 16;
  localparam int FracW      = 8;
  localparam int CoordW     = $clog2(MaxSide);
  localparam int PosW       = CoordW + FracW;
  localparam int ProdW      = WorldW + ScaleW + 1;
  localparam int PosFullW   = ProdW - ScaleFracW;
  localparam int RowW       = TexelW + FracW;
  localparam int AccW       = RowW + FracW;
  localparam int PaddrW     = 4;
  localparam int PdataW     = 32;

  localparam logic [TexelW-1:0] DensityOne = TexelW'(16384);
  localparam logic [TexelW-1:0] DensityMax = '1;
  localparam logic [ScaleW-1:0] ScaleOne   = ScaleW'(65536);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_SCALE_X    = 2'd2,
    REG_SCALE_Z    = 2'd3
  } reg_idx_e;

  // one texel bank: one write port, two registered read ports
  typedef struct packed {
    logic              we;
    logic [BankAw-1:0] waddr;
    logic [TexelW-1:0] wdata;
    logic              rd_en;
    logic [BankAw-1:0] raddr0;
    logic [BankAw-1:0] raddr1;
  } bank_req_t;

endpackage

// ===== src/bilinear_density_map_sampler.sv =====
// channel  direction  handshake                 payload
// cfg      in         psel/penable/pwrite       paddr, pwdata (prdata back, pready tied high)
// in       in         in_valid_i / in_ready_o   op_i, texel_index_i, texel_value_i,
//                                               world_x_i, world_z_i
// out      out        out_valid_o / out_ready_i density_o
//
// one item per cycle while out_ready_i does not stall it; a sample passes through the
// six register stages: scale multiply, edge clamp, row address, texel read, x blend, z blend
// texel store is two 32K x 16 banks split on address parity, each one write and two reads
// per cycle, so the four neighbors of a sample are read together
// reset clears valid bits and map sizes, sets both scales to 1.0; the store is undefined
// until written and has no clearing pass; a full stage holds only while the stage after it
// is full, so bubbles close up and items keep entering while a result waits on out_ready_i
module bilinear_density_map_sampler import bdms_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [PdataW-1:0]        pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [AddrW-1:0]         texel_index_i,
  input  logic [TexelW-1:0]        texel_value_i,
  input  logic signed [WorldW-1:0] world_x_i,
  input  logic signed [WorldW-1:0] world_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [TexelW-1:0]        density_o
);

  // configuration
  logic [SideW-1:0]  map_width_q, map_height_q;
  logic [ScaleW-1:0] scale_x_q, scale_z_q;
  logic [SideW-1:0]  eff_w, eff_h;
  logic              no_map;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= '0;
      map_height_q <= '0;
      scale_x_q    <= ScaleOne;
      scale_z_q    <= ScaleOne;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_MAP_WIDTH:  map_width_q  <= pwdata[SideW-1:0];
        REG_MAP_HEIGHT: map_height_q <= pwdata[SideW-1:0];
        REG_SCALE_X:    scale_x_q    <= pwdata[ScaleW-1:0];
        REG_SCALE_Z:    scale_z_q    <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[3:2]))
      REG_MAP_WIDTH:  prdata = PdataW'(map_width_q);
      REG_MAP_HEIGHT: prdata = PdataW'(map_height_q);
      REG_SCALE_X:    prdata = PdataW'(scale_x_q);
      REG_SCALE_Z:    prdata = PdataW'(scale_z_q);
      default:        prdata = '0;
    endcase
  end

  assign eff_w  = (map_width_q > SideW'(MaxSide)) ? SideW'(MaxSide) : map_width_q;
  assign eff_h  = (map_height_q > SideW'(MaxSide)) ? SideW'(MaxSide) : map_height_q;
  assign no_map = (eff_w == '0) || (eff_h == '0);

  // texel position in q.8, clamped to [0, side - 1]
  function automatic logic [PosW-1:0] to_pos(input logic signed [ProdW-1:0] prod,
                                             input logic [SideW-1:0] side);
    logic [PosFullW-1:0] p;
    logic [PosW-1:0]     top;
    p   = prod[ProdW-1:ScaleFracW];
    top = {CoordW'(side - 1'b1), {FracW{1'b0}}};
    if (prod[ProdW-1] || (prod == '0)) begin
      return '0;
    end else if (p > PosFullW'(top)) begin
      return top;
    end else begin
      return p[PosW-1:0];
    end
  endfunction

  // stage enables, a stage loads when empty or when its item moves on
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en6;
  op_e  op5_q;

  assign en6        = !out_valid_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) out_valid_q <= v5_q && (op5_q == OP_SAMPLE);
    end
  end

  // stage 1: scale to texel space
  op_e                     op1_q;
  logic [AddrW-1:0]        idx1_q;
  logic [TexelW-1:0]       val1_q;
  logic signed [ProdW-1:0] prod_x1_q, prod_z1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q     <= op_e'(op_i);
      idx1_q    <= texel_index_i;
      val1_q    <= texel_value_i;
      prod_x1_q <= world_x_i * $signed({1'b0, scale_x_q});
      prod_z1_q <= world_z_i * $signed({1'b0, scale_z_q});
    end
  end

  // stage 2: clamp to the map edges
  op_e               op2_q;
  logic [AddrW-1:0]  idx2_q;
  logic [TexelW-1:0] val2_q;
  logic [PosW-1:0]   pos_x2_q, pos_z2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q    <= op1_q;
      idx2_q   <= idx1_q;
      val2_q   <= val1_q;
      pos_x2_q <= to_pos(prod_x1_q, eff_w);
      pos_z2_q <= to_pos(prod_z1_q, eff_h);
    end
  end

  // stage 3: row address of the upper-left texel and the edge flags
  logic [CoordW-1:0]        x0, z0;
  logic [CoordW+SideW-1:0]  row_base;
  op_e                      op3_q;
  logic [AddrW-1:0]         idx3_q;
  logic [TexelW-1:0]        val3_q;
  logic [AddrW-1:0]         addr3_q;
  logic                     x_same3_q, z_step3_q;
  logic [FracW-1:0]         fx3_q, fz3_q;

  assign x0       = pos_x2_q[PosW-1:FracW];
  assign z0       = pos_z2_q[PosW-1:FracW];
  assign row_base = (CoordW+SideW)'(z0) * (CoordW+SideW)'(eff_w);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      op3_q     <= op2_q;
      idx3_q    <= idx2_q;
      val3_q    <= val2_q;
      addr3_q   <= AddrW'(row_base + (CoordW+SideW)'(x0));
      x_same3_q <= !((SideW'(x0) + 1'b1) < eff_w);
      z_step3_q <= (SideW'(z0) + 1'b1) < eff_h;
      fx3_q     <= pos_x2_q[FracW-1:0];
      fz3_q     <= pos_z2_q[FracW-1:0];
    end
  end

  // stage 4: texel read from the parity banks, writes land here too
  logic [AddrW-1:0]  a_r0, a_r1, a_r0p, a_r1p;
  logic [AddrW-1:0]  ev_r0, ev_r1, od_r0, od_r1;
  logic              wr_now;
  bank_req_t         even_req, odd_req;
  logic [TexelW-1:0] even_rd0, even_rd1, odd_rd0, odd_rd1;
  op_e               op4_q;
  logic              par_r0_4_q, par_r1_4_q, x_same4_q;
  logic [FracW-1:0]  fx4_q, fz4_q;

  assign a_r0   = addr3_q;
  assign a_r1   = addr3_q + (z_step3_q ? AddrW'(eff_w) : '0);
  assign a_r0p  = a_r0 + 1'b1;
  assign a_r1p  = a_r1 + 1'b1;
  // the pair {a, a + 1} always has one even and one odd address
  assign ev_r0  = a_r0[0] ? a_r0p : a_r0;
  assign od_r0  = a_r0[0] ? a_r0  : a_r0p;
  assign ev_r1  = a_r1[0] ? a_r1p : a_r1;
  assign od_r1  = a_r1[0] ? a_r1  : a_r1p;
  assign wr_now = en4 && v3_q && (op3_q == OP_WRITE);

  always_comb begin
    even_req.we     = wr_now && !idx3_q[0];
    even_req.waddr  = idx3_q[AddrW-1:1];
    even_req.wdata  = val3_q;
    even_req.rd_en  = en4;
    even_req.raddr0 = ev_r0[AddrW-1:1];
    even_req.raddr1 = ev_r1[AddrW-1:1];
    odd_req.we      = wr_now && idx3_q[0];
    odd_req.waddr   = idx3_q[AddrW-1:1];
    odd_req.wdata   = val3_q;
    odd_req.rd_en   = en4;
    odd_req.raddr0  = od_r0[AddrW-1:1];
    odd_req.raddr1  = od_r1[AddrW-1:1];
  end

  bdms_ram u_even_bank (
    .clk_i    (clk_i),
    .req_i    (even_req),
    .rdata0_o (even_rd0),
    .rdata1_o (even_rd1)
  );

  bdms_ram u_odd_bank (
    .clk_i    (clk_i),
    .req_i    (odd_req),
    .rdata0_o (odd_rd0),
    .rdata1_o (odd_rd1)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      op4_q      <= op3_q;
      par_r0_4_q <= a_r0[0];
      par_r1_4_q <= a_r1[0];
      x_same4_q  <= x_same3_q;
      fx4_q      <= fx3_q;
      fz4_q      <= fz3_q;
    end
  end

  // stage 5: blend along x
  logic [TexelW-1:0] t00, t01, t10, t11;
  logic [FracW:0]    wx0, wx1;
  logic [RowW-1:0]   top5_q, bot5_q;
  logic [FracW-1:0]  fz5_q;

  assign t00 = par_r0_4_q ? odd_rd0 : even_rd0;
  assign t01 = x_same4_q ? t00 : (par_r0_4_q ? even_rd0 : odd_rd0);
  assign t10 = par_r1_4_q ? odd_rd1 : even_rd1;
  assign t11 = x_same4_q ? t10 : (par_r1_4_q ? even_rd1 : odd_rd1);
  assign wx1 = (FracW+1)'(fx4_q);
  assign wx0 = (FracW+1)'(2**FracW) - wx1;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      op5_q  <= op4_q;
      fz5_q  <= fz4_q;
      top5_q <= RowW'(t00) * RowW'(wx0) + RowW'(t01) * RowW'(wx1);
      bot5_q <= RowW'(t10) * RowW'(wx0) + RowW'(t11) * RowW'(wx1);
    end
  end

  // stage 6: blend along z, round half up, saturate; 1.0 when no map is set
  logic [FracW:0]          wz0, wz1;
  logic [AccW-1:0]         acc;
  logic [AccW:0]           acc_rnd;
  logic [AccW-TexelW:0]    acc_top;
  logic [TexelW-1:0]       density_d, density_q;

  assign wz1     = (FracW+1)'(fz5_q);
  assign wz0     = (FracW+1)'(2**FracW) - wz1;
  assign acc     = AccW'(top5_q) * AccW'(wz0) + AccW'(bot5_q) * AccW'(wz1);
  assign acc_rnd = (AccW+1)'(acc) + (AccW+1)'(2**(AccW-TexelW-1));
  assign acc_top = acc_rnd[AccW:AccW-TexelW];

  always_comb begin
    if (no_map) begin
      density_d = DensityOne;
    end else if (acc_top[AccW-TexelW]) begin
      density_d = DensityMax;
    end else begin
      density_d = acc_top[TexelW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      density_q <= density_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign density_o   = density_q;

endmodule

// ===== src/bdms_ram.sv =====
module bdms_ram import bdms_pkg::*; (
  input  logic              clk_i,
  input  bank_req_t         req_i,
  output logic [TexelW-1:0] rdata0_o,
  output logic [TexelW-1:0] rdata1_o
);

  logic [TexelW-1:0] mem_q [2**BankAw];
  logic [TexelW-1:0] rdata0_q;
  logic [TexelW-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata0_q <= mem_q[req_i.raddr0];
      rdata1_q <= mem_q[req_i.raddr1];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== tb/density_sampler_checker.sv =====
module density_sampler_checker import bdms_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [PdataW-1:0]        pwdata,
  input  logic                     pready,
  input  logic                     in_valid_i,
  input  logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [AddrW-1:0]         texel_index_i,
  input  logic [TexelW-1:0]        texel_value_i,
  input  logic signed [WorldW-1:0] world_x_i,
  input  logic signed [WorldW-1:0] world_z_i,
  input  logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic [TexelW-1:0]        density_o,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SideCap = 256;
  localparam logic [15:0] UnitDensity = 16'd16384;

  logic [8:0]  width_cfg;
  logic [8:0]  height_cfg;
  logic [23:0] scale_x_cfg;
  logic [23:0] scale_z_cfg;
  logic [15:0] texel_mem [65536];
  logic [15:0] expected_density [$];
  logic [15:0] want;
  int          mismatch_total = 0;

  // world position to clamped Q.8 texel position along one axis
  function automatic int unsigned texel_pos_q8(logic signed [23:0] world, logic [23:0] scale,
                                               int unsigned side);
    longint prod;
    longint lim;
    prod = longint'(world) * longint'({1'b0, scale});
    lim  = (longint'(side) - 1) << 8;
    if (prod <= 0) return 0;
    prod = prod >>> 16;
    return (prod > lim) ? 32'(lim) : 32'(prod);
  endfunction

  function automatic logic [15:0] texel_at(int unsigned z, int unsigned x, int unsigned w);
    return texel_mem[(z * w + x) & 32'hFFFF];
  endfunction

  function automatic logic [15:0] predict_density(logic signed [23:0] wx,
                                                  logic signed [23:0] wz);
    int unsigned       w, h, px, pz, x0, x1, z0, z1, fx, fz;
    longint unsigned   row_top, row_bot, acc;
    w = (width_cfg > SideCap) ? SideCap : width_cfg;
    h = (height_cfg > SideCap) ? SideCap : height_cfg;
    if (w == 0 || h == 0) return UnitDensity;
    px = texel_pos_q8(wx, scale_x_cfg, w);
    pz = texel_pos_q8(wz, scale_z_cfg, h);
    x0 = px >> 8;
    z0 = pz >> 8;
    fx = px & 8'hFF;
    fz = pz & 8'hFF;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
    row_top = texel_at(z0, x0, w) * (256 - fx) + texel_at(z0, x1, w) * fx;
    row_bot = texel_at(z1, x0, w) * (256 - fx) + texel_at(z1, x1, w) * fx;
    acc = row_top * (256 - fz) + row_bot * fz;
    acc = (acc + 32768) >> 16;
    return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg   <= '0;
      height_cfg  <= '0;
      scale_x_cfg <= 24'd65536;
      scale_z_cfg <= 24'd65536;
      expected_density.delete();
      pending_o    <= 0;
      fail_count_o <= mismatch_total;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_MAP_WIDTH:  width_cfg   <= pwdata[8:0];
          REG_MAP_HEIGHT: height_cfg  <= pwdata[8:0];
          REG_SCALE_X:    scale_x_cfg <= pwdata[23:0];
          REG_SCALE_Z:    scale_z_cfg <= pwdata[23:0];
          default: ;
        endcase
      end
      // results leave in order, so the oldest prediction is the one to match
      if (out_valid_o && out_ready_i) begin
        if (expected_density.size() == 0) begin
          $display("%0t: density %h with no item expected", $time, density_o);
          mismatch_total++;
        end else begin
          want = expected_density.pop_front();
          if (want !== density_o) begin
            $display("%0t: density mismatch, expected %h actual %h", $time, want, density_o);
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (op_i == OP_WRITE) begin
          texel_mem[texel_index_i] <= texel_value_i;
        end else begin
          expected_density.push_back(predict_density(world_x_i, world_z_i));
        end
      end
      pending_o    <= expected_density.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdms_pkg::*;

  localparam int unsigned SideCap        = 256;
  localparam int          NumPhases      = 11;
  localparam int          ItemsPerPhase  = 145;
  localparam int          HoldCycles     = 60;

  localparam int unsigned PhaseW [NumPhases] = '{256, 511, 1, 5, 0, 9, 17, 256, 2, 37, 3};
  localparam int unsigned PhaseH [NumPhases] = '{256, 3, 1, 300, 7, 0, 13, 1, 256, 41, 2};
  localparam int unsigned PhaseSx [NumPhases] =
    '{65536, 24'hFFFFFF, 0, 12345, 65536, 65536, 32768, 1, 0, 0, 65536};
  localparam int unsigned PhaseSz [NumPhases] =
    '{65536, 65536, 0, 24'hFFFFFF, 65536, 65536, 196608, 0, 0, 0, 65536};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PaddrW-1:0]        paddr;
  logic [PdataW-1:0]        pwdata;
  logic [PdataW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     op_i;
  logic [AddrW-1:0]         texel_index_i;
  logic [TexelW-1:0]        texel_value_i;
  logic signed [WorldW-1:0] world_x_i;
  logic signed [WorldW-1:0] world_z_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [TexelW-1:0]        density_o;
  int                       fail_count;
  int                       pending;

  // local copy of the map setup, used to keep samples on written texels
  int unsigned map_w;
  int unsigned map_h;
  logic [23:0] step_x;
  logic [23:0] step_z;
  bit          texel_written [65536];
  int          items_sent = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_requests = 0;
  int          holds_served = 0;

  bilinear_density_map_sampler uut (.*);

  density_sampler_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .op_i, .texel_index_i, .texel_value_i,
    .world_x_i, .world_z_i, .out_valid_o, .out_ready_i, .density_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int cnt;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        out_ready_i = 1'b0;
        for (cnt = 0; cnt < HoldCycles; cnt++) @(negedge clk_i);
        holds_served++;
      end
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int unsigned eff_side(int unsigned s);
    return (s > SideCap) ? SideCap : s;
  endfunction

  function automatic int unsigned axis_q8(logic signed [23:0] world, logic [23:0] scale,
                                          int unsigned side);
    longint prod;
    longint lim;
    prod = longint'(world) * longint'({1'b0, scale});
    lim  = (longint'(side) - 1) << 8;
    if (prod <= 0) return 0;
    prod = prod >>> 16;
    return (prod > lim) ? 32'(lim) : 32'(prod);
  endfunction

  // world coordinate that mostly lands inside the map, sometimes anywhere
  function automatic logic signed [23:0] aim_world(int unsigned side, logic [23:0] scale);
    longint      v;
    int unsigned pick;
    pick = $urandom_range(9);
    if (side == 0 || scale == 0 || pick == 0) return 24'($urandom);
    if (pick == 1) begin
      v = -longint'($urandom_range(4096));
    end else begin
      v = (longint'($urandom_range(side * 256 + 127)) << 16) / longint'(scale)
          + $urandom_range(1);
    end
    if (v > 8388607) v = 8388607;
    return v[23:0];
  endfunction

  task automatic send_item(op_e op, logic [15:0] idx, logic [15:0] val,
                           logic signed [23:0] wx, logic signed [23:0] wz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i          = op;
    texel_index_i = idx;
    texel_value_i = val;
    world_x_i     = wx;
    world_z_i     = wz;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_write(logic [15:0] idx, logic [15:0] val);
    texel_written[idx] = 1'b1;
    send_item(OP_WRITE, idx, val, 24'($urandom), 24'($urandom));
  endtask

  // fill any of the four neighbor texels that were never written
  task automatic make_readable(logic signed [23:0] wx, logic signed [23:0] wz);
    int unsigned w, h, px, pz, x0, x1, z0, z1;
    int unsigned addr [4];
    w  = eff_side(map_w);
    h  = eff_side(map_h);
    px = axis_q8(wx, step_x, w);
    pz = axis_q8(wz, step_z, h);
    x0 = px >> 8;
    z0 = pz >> 8;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
    addr = '{(z0 * w + x0) & 32'hFFFF, (z0 * w + x1) & 32'hFFFF,
             (z1 * w + x0) & 32'hFFFF, (z1 * w + x1) & 32'hFFFF};
    foreach (addr[i]) begin
      if (!texel_written[addr[i]]) send_write(addr[i][15:0], 16'($urandom));
    end
  endtask

  task automatic send_sample(logic signed [23:0] wx, logic signed [23:0] wz);
    if (eff_side(map_w) != 0 && eff_side(map_h) != 0) make_readable(wx, wz);
    send_item(OP_SAMPLE, 16'($urandom), 16'($urandom), wx, wz);
  endtask

  task automatic random_item();
    int unsigned roll;
    int unsigned cells;
    roll  = $urandom_range(99);
    cells = eff_side(map_w) * eff_side(map_h);
    if (roll < 12) begin
      send_write(16'($urandom), 16'($urandom));
    end else if (roll < 25 && cells != 0) begin
      send_write(16'($urandom_range(cells - 1)), 16'($urandom));
    end else begin
      send_sample(aim_world(eff_side(map_w), step_x), aim_world(eff_side(map_h), step_z));
    end
  endtask

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    paddr   = PaddrW'({idx, 2'b00});
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_MAP_WIDTH:  map_w  = value[8:0];
      REG_MAP_HEIGHT: map_h  = value[8:0];
      REG_SCALE_X:    step_x = value[23:0];
      REG_SCALE_Z:    step_z = value[23:0];
      default: ;
    endcase
  endtask

  task automatic set_map(int unsigned w, int unsigned h, logic [23:0] sx, logic [23:0] sz);
    write_register(REG_MAP_WIDTH, w);
    write_register(REG_MAP_HEIGHT, h);
    write_register(REG_SCALE_X, sx);
    write_register(REG_SCALE_Z, sz);
  endtask

  // drain results, then give in-flight writes time to land
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    logic [23:0] sx, sz;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    op_i          = OP_WRITE;
    texel_index_i = '0;
    texel_value_i = '0;
    world_x_i     = '0;
    world_z_i     = '0;
    map_w         = 0;
    map_h         = 0;
    step_x        = 24'd65536;
    step_z        = 24'd65536;
    send_idle_pct = 23;
    recv_idle_pct = 76;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // no map after reset: every sample gives 1.0
    send_write(16'h0000, 16'h0000);
    send_write(16'hFFFF, 16'hFFFF);
    send_sample(24'sh000000, 24'sh000000);
    send_sample(24'sh800000, 24'sh7FFFFF);
    send_sample(24'sh7FFFFF, 24'sh800000);

    // 2x2 map, three full-scale texels and one zero: fractions, edges and negative positions
    wait_idle();
    write_register(REG_MAP_WIDTH, 2);
    write_register(REG_MAP_HEIGHT, 2);
    send_write(16'd0, 16'hFFFF);
    send_write(16'd1, 16'hFFFF);
    send_write(16'd2, 16'hFFFF);
    send_write(16'd3, 16'h0000);
    send_sample(24'sh000000, 24'sh000000);
    send_sample(24'sh000080, 24'sh000080);
    send_sample(24'sh0000FF, 24'sh0000FF);
    send_sample(-24'sd1, -24'sd1);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF);
    send_sample(24'sh000080, 24'sh000180);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 4) ? 23 : (ph < 8) ? 76 : 0;
      recv_idle_pct = (ph < 4) ? 76 : (ph < 8) ? 23 : 0;
      sx = (ph == 8 || ph == 9) ? 24'($urandom) : 24'(PhaseSx[ph]);
      sz = (ph == 8 || ph == 9) ? 24'($urandom_range(24'h03FFFF)) : 24'(PhaseSz[ph]);
      set_map(PhaseW[ph], PhaseH[ph], sx, sz);
      // long output stall while items keep coming, so the pipeline backs up
      if (ph == 0 || ph == 8) hold_requests++;
      for (int n = items_sent + ItemsPerPhase; items_sent < n; ) random_item();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bdms_pkg.sv
src/bdms_ram.sv
src/bilinear_density_map_sampler.sv
tb/density_sampler_checker.sv
tb/tb.sv
